/* hw/rtl/epal_pkg.sv */
package epal_pkg;

  localparam int POOL_ENTRIES_DEF = 32;
  localparam int KIND_BITS_DEF    = 8;

  // fixed field widths of the ports
  localparam int OP_W     = 2;
  localparam int SLOT_W_IO = 5;
  localparam int KIND_W_IO = 8;
  localparam int STATUS_W = 3;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_POST  = 2'd2;
  localparam logic [OP_W-1:0] OP_POP   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY_POSTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_QUEUE_EMPTY    = 3'd4;

  typedef struct packed {
    logic take;
    logic finish_pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic pop_read;
  } dp_stat_t;

endpackage

/* hw/rtl/epal_ram.sv */
module epal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/epal_ctrl.sv */
module epal_ctrl import epal_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic state;
  logic state_next;

  assign in_stall       = !((state == S_IDLE) && stat.out_free);
  assign cmd.take       = in_valid && !in_stall;
  assign cmd.finish_pop = (state == S_POP);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.take && stat.pop_read) begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/epal_dpath.sv */
module epal_dpath import epal_pkg::*; #(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
  parameter int KIND_BITS    = KIND_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output dp_stat_t             stat,
  input  logic [OP_W-1:0]      operation,
  input  logic [SLOT_W_IO-1:0] slot_index,
  input  logic [KIND_W_IO-1:0] event_kind,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  status,
  output logic [SLOT_W_IO-1:0] result_slot,
  output logic [KIND_W_IO-1:0] result_kind
);

  localparam int SLOT_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int HEAD_W = $clog2(POOL_ENTRIES + 1);
  localparam logic [HEAD_W-1:0] HEAD_EMPTY = HEAD_W'(POOL_ENTRIES);

  logic [POOL_ENTRIES-1:0] used_mask;
  logic [POOL_ENTRIES-1:0] posted_mask;
  logic [HEAD_W-1:0]       queue_head;

  logic [SLOT_W-1:0]    slot_w;
  logic                 slot_in_range;
  logic                 found;
  logic [SLOT_W-1:0]    free_idx;
  logic [KIND_BITS-1:0] kind_in;
  logic                 queue_empty;
  logic                 free_ok;
  logic                 post_ok;
  logic                 load_out;

  logic [STATUS_W-1:0]  res_status;
  logic [SLOT_W_IO-1:0] res_slot;
  logic [KIND_W_IO-1:0] res_kind;

  logic [HEAD_W-1:0]    link_rd;
  logic [KIND_BITS-1:0] kind_rd;
  logic [HEAD_W-1:0]    link_clamped;

  assign slot_w        = SLOT_W'(slot_index);
  assign slot_in_range = (int'(slot_index) < POOL_ENTRIES);
  assign kind_in       = KIND_BITS'(event_kind);
  assign queue_empty   = (queue_head >= HEAD_EMPTY);
  assign free_ok       = slot_in_range && used_mask[slot_w];
  assign post_ok       = slot_in_range && !posted_mask[slot_w];
  assign link_clamped  = (link_rd > HEAD_EMPTY) ? HEAD_EMPTY : link_rd;

  // lowest free slot
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (!used_mask[i]) begin
        found    = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign stat.out_free = !out_valid || !out_stall;
  assign stat.pop_read = (operation == OP_POP) && !queue_empty;

  epal_ram #(
    .WIDTH(HEAD_W),
    .DEPTH(POOL_ENTRIES)
  ) u_link_ram (
    .clk  (clk),
    .we   (cmd.take && (operation == OP_POST) && post_ok),
    .waddr(slot_w),
    .wdata(queue_head),
    .re   (cmd.take && stat.pop_read),
    .raddr(SLOT_W'(queue_head)),
    .rdata(link_rd)
  );

  epal_ram #(
    .WIDTH(KIND_BITS),
    .DEPTH(POOL_ENTRIES)
  ) u_kind_ram (
    .clk  (clk),
    .we   (cmd.take && (operation == OP_ALLOC) && found),
    .waddr(free_idx),
    .wdata(kind_in),
    .re   (cmd.take && stat.pop_read),
    .raddr(SLOT_W'(queue_head)),
    .rdata(kind_rd)
  );

  always_comb begin
    res_status = ST_OK;
    res_slot   = '0;
    res_kind   = '0;
    if (cmd.finish_pop) begin
      res_slot = SLOT_W_IO'(queue_head);
      res_kind = KIND_W_IO'(kind_rd);
    end else begin
      unique case (operation)
        OP_ALLOC: begin
          if (found) begin
            res_slot = SLOT_W_IO'(free_idx);
            res_kind = KIND_W_IO'(kind_in);
          end else begin
            res_status = ST_EXHAUSTED;
          end
        end
        OP_FREE: begin
          if (!free_ok) begin
            res_status = ST_DOUBLE_FREE;
          end
        end
        OP_POST: begin
          if (!post_ok) begin
            res_status = ST_ALREADY_POSTED;
          end
        end
        OP_POP: begin
          res_status = ST_QUEUE_EMPTY;
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  // a pop from a nonempty queue waits in S_POP for the registered memory words
  assign load_out = (cmd.take && !stat.pop_read) || cmd.finish_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_mask   <= '0;
      posted_mask <= '0;
      queue_head  <= HEAD_EMPTY;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.take) begin
        unique case (operation)
          OP_ALLOC: begin
            if (found) begin
              used_mask[free_idx] <= 1'b1;
            end
          end
          OP_FREE: begin
            if (free_ok) begin
              used_mask[slot_w] <= 1'b0;
            end
          end
          OP_POST: begin
            if (post_ok) begin
              posted_mask[slot_w] <= 1'b1;
              queue_head          <= HEAD_W'(slot_w);
            end
          end
          OP_POP: begin
          end
          default: begin
          end
        endcase
      end
      if (cmd.finish_pop) begin
        posted_mask[SLOT_W'(queue_head)] <= 1'b0;
        queue_head                       <= link_clamped;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= res_status;
      result_slot <= res_slot;
      result_kind <= res_kind;
    end
  end

endmodule

/* hw/rtl/event_pool_allocator_lifo_top.sv */
// pool of event slots with lowest-free allocation and a lifo post queue.
// one word in gives one word out. alloc, free, post and a pop of an empty
// queue load the result register directly; a pop of a nonempty queue first
// passes S_POP for the registered read of the link and kind memories.
// a new word is taken while the result register is empty or being taken in
// the same cycle, so the sustained rate is one word per cycle, except while
// a pop waits in S_POP. link and kind memories are not cleared by reset.
module event_pool_allocator_lifo_top import epal_pkg::*; #(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
  parameter int KIND_BITS    = KIND_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      operation,
  input  logic [SLOT_W_IO-1:0] slot_index,
  input  logic [KIND_W_IO-1:0] event_kind,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [SLOT_W_IO-1:0] result_slot,
  output logic [KIND_W_IO-1:0] result_kind
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  epal_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  epal_dpath #(
    .POOL_ENTRIES(POOL_ENTRIES),
    .KIND_BITS   (KIND_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .operation  (operation),
    .slot_index (slot_index),
    .event_kind (event_kind),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .status     (status),
    .result_slot(result_slot),
    .result_kind(result_kind)
  );

endmodule

/* hw/rtl/epal_checker.sv */
module epal_checker import epal_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [OP_W-1:0]      operation,
  input logic [SLOT_W_IO-1:0] slot_index,
  input logic [KIND_W_IO-1:0] event_kind,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [STATUS_W-1:0]  status,
  input logic [SLOT_W_IO-1:0] result_slot,
  input logic [KIND_W_IO-1:0] result_kind
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_slot)
      && $stable(result_kind))
    else $error("stalled result word changed");

  // no new word while a result is stuck
  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result stalled");

  // everything but a pop answers in the next cycle
  a_fast_answer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (operation != OP_POP) |=> out_valid)
    else $error("missing one-cycle result");

  // error answers carry no slot and no kind
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (result_slot == '0) && (result_kind == '0))
    else $error("error result with nonzero payload");

endmodule

bind event_pool_allocator_lifo_top epal_checker u_epal_checker (.*);
